// ----- design/sha1h_pkg.sv -----
// shared types, constants and round functions for the sha-1 message hasher
package sha1h_pkg;

    typedef logic [31:0] word_t;

    localparam word_t Iv0 = 32'h67452301;
    localparam word_t Iv1 = 32'hEFCDAB89;
    localparam word_t Iv2 = 32'h98BADCFE;
    localparam word_t Iv3 = 32'h10325476;
    localparam word_t Iv4 = 32'hC3D2E1F0;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PadMarker = 8'h80;
    localparam logic [6:0] LastRound = 7'd79;
    localparam logic [5:0] LastPos   = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_DONE
    } sha1h_state_t;

    // schedule memory control
    typedef struct packed {
        logic       fill_we;
        logic [3:0] fill_addr;
        logic       rnd_we;
        logic [3:0] rnd_addr;
        logic [6:0] rd_idx;
    } sch_ctl_t;

    // round datapath control
    typedef struct packed {
        logic       chain_init;
        logic       load;
        logic       step;
        logic       fold;
        logic [6:0] t;
    } rnd_ctl_t;

    function automatic word_t round_f(input logic [6:0] t, input word_t b,
                                      input word_t c, input word_t d);
        word_t r;
        if (t < 7'd20)
            r = (b & c) | (~b & d);
        else if (t < 7'd40)
            r = b ^ c ^ d;
        else if (t < 7'd60)
            r = (b & c) | (b & d) | (c & d);
        else
            r = b ^ c ^ d;
        return r;
    endfunction

    function automatic word_t round_k(input logic [6:0] t);
        word_t r;
        if (t < 7'd20)
            r = K0;
        else if (t < 7'd40)
            r = K1;
        else if (t < 7'd60)
            r = K2;
        else
            r = K3;
        return r;
    endfunction

endpackage

// ----- design/sha1h_sched.sv -----
// message block and schedule memory, two copies with two read ports each
module sha1h_sched
    import sha1h_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sch_ctl_t ctl,
    input  word_t    fill_data,
    output word_t    w
);

    word_t mem_a [16];
    word_t mem_b [16];

    word_t      qa0_reg;
    word_t      qa1_reg;
    word_t      qb0_reg;
    word_t      qb1_reg;
    logic       is_msg_reg;
    logic       is_msg_next;
    logic [3:0] ra0;
    logic [3:0] ra1;
    logic [3:0] rb0;
    logic [3:0] rb1;
    logic       we;
    logic [3:0] waddr;
    word_t      wdata;
    word_t      mix;

    // taps of w[t-16], w[t-14], w[t-8] and w[t-3]
    assign ra0 = ctl.rd_idx[3:0];
    assign ra1 = ctl.rd_idx[3:0] + 4'd2;
    assign rb0 = ctl.rd_idx[3:0] + 4'd8;
    assign rb1 = ctl.rd_idx[3:0] + 4'd13;
    assign is_msg_next = (ctl.rd_idx[6:4] == 3'd0);

    assign we    = ctl.fill_we | ctl.rnd_we;
    assign waddr = ctl.fill_we ? ctl.fill_addr : ctl.rnd_addr;
    assign wdata = ctl.fill_we ? fill_data : w;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_a[waddr] <= wdata;
            mem_b[waddr] <= wdata;
        end
        qa0_reg <= mem_a[ra0];
        qa1_reg <= mem_a[ra1];
        qb0_reg <= mem_b[rb0];
        qb1_reg <= mem_b[rb1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            is_msg_reg <= 1'b1;
        else
            is_msg_reg <= is_msg_next;
    end

    assign mix = qa0_reg ^ qa1_reg ^ qb0_reg ^ qb1_reg;
    assign w   = is_msg_reg ? qa0_reg : {mix[30:0], mix[31]};

endmodule

// ----- design/sha1h_round.sv -----
// chaining words and the one-round-per-cycle compression datapath
module sha1h_round
    import sha1h_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rnd_ctl_t ctl,
    input  word_t    w,
    output word_t    chain [5]
);

    word_t h_reg [5];
    word_t a_reg;
    word_t b_reg;
    word_t c_reg;
    word_t d_reg;
    word_t e_reg;
    word_t tmp;

    assign tmp = {a_reg[26:0], a_reg[31:27]} + round_f(ctl.t, b_reg, c_reg, d_reg)
               + e_reg + round_k(ctl.t) + w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= Iv0;
            h_reg[1] <= Iv1;
            h_reg[2] <= Iv2;
            h_reg[3] <= Iv3;
            h_reg[4] <= Iv4;
        end
        else if (ctl.chain_init)
        begin
            h_reg[0] <= Iv0;
            h_reg[1] <= Iv1;
            h_reg[2] <= Iv2;
            h_reg[3] <= Iv3;
            h_reg[4] <= Iv4;
        end
        else if (ctl.fold)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (ctl.step)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign chain = h_reg;

endmodule

// ----- design/sha1_message_hasher.sv -----
// sha-1 message hasher top level: byte intake, padding control and digest output
//
// Takes one message byte per transaction; an end-of-message transaction, which
// may also carry a last byte, closes the message, and the 160-bit digest is
// then presented on the output. A byte that does not complete a 64-byte block
// is simply stored. The byte that completes a block starts a compression (one
// memory read to prime the schedule, 80 rounds at one per cycle on a single
// round datapath, then a fold into the chaining words), and no input is taken
// until it ends. Closing a message writes the padding and the length one byte
// per cycle into the block memory (9 to 72 bytes), runs one or two
// compressions, and then holds the digest in an output register; input is
// taken again while that digest waits, unless a second digest is ready before
// the first is taken.
module sha1_message_hasher
    import sha1h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word0,
    output logic [31:0] digest_word1,
    output logic [31:0] digest_word2,
    output logic [31:0] digest_word3,
    output logic [31:0] digest_word4
);

    sha1h_state_t state_reg;
    sha1h_state_t state_next;

    logic [63:0] bc_reg;
    logic [63:0] bc_next;
    logic [63:0] len_reg;
    logic [23:0] acc_reg;
    logic [6:0]  rnd_reg;
    logic [6:0]  rnd_next;
    logic        closing_reg;
    logic        marker_reg;
    logic        wrap_reg;
    logic        len_done_reg;
    logic        dout_valid_reg;
    word_t       dig_reg [5];

    logic [5:0]  pos;
    logic        in_fire;
    logic        absorb_en;
    logic        pad_en;
    logic        len_zone;
    logic        done_exit;
    logic [7:0]  pad_byte;
    logic [7:0]  abs_byte;
    logic [63:0] len_shift;
    word_t       fill_data;
    word_t       w;
    word_t       chain [5];
    sch_ctl_t    sch_ctl;
    rnd_ctl_t    rnd_ctl;

    assign pos       = bc_reg[8:3];
    assign len_zone  = marker_reg && (pos[5:3] == 3'b111) && !wrap_reg;
    assign len_shift = len_reg << {pos[2:0], 3'b000};
    assign fill_data = {acc_reg, abs_byte};

    always_comb
    begin
        if (!marker_reg)
            pad_byte = PadMarker;
        else if (len_zone)
            pad_byte = len_shift[63:56];
        else
            pad_byte = 8'h00;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte && (pos == LastPos))
                        state_next = ST_PREP;
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (pos == LastPos)
                    state_next = ST_PREP;
            end
            ST_PREP:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (rnd_reg == LastRound)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (len_done_reg)
                    state_next = ST_DONE;
                else if (closing_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_DONE:
            begin
                if (!dout_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready  = 1'b0;
        pad_en    = 1'b0;
        done_exit = 1'b0;
        rnd_next  = rnd_reg;
        rnd_ctl   = '0;
        sch_ctl   = '0;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_PAD:
                pad_en = 1'b1;
            ST_PREP:
            begin
                rnd_next    = 7'd0;
                rnd_ctl.load = 1'b1;
            end
            ST_ROUND:
            begin
                rnd_next         = rnd_reg + 7'd1;
                rnd_ctl.step     = 1'b1;
                sch_ctl.rnd_we   = 1'b1;
                sch_ctl.rnd_addr = rnd_reg[3:0];
                sch_ctl.rd_idx   = rnd_reg + 7'd1;
            end
            ST_FOLD:
                rnd_ctl.fold = 1'b1;
            ST_DONE:
                done_exit = !dout_valid_reg || out_ready;
            default:
                in_ready = 1'b0;
        endcase
        in_fire            = in_valid && in_ready;
        absorb_en          = (in_fire && has_byte) || pad_en;
        abs_byte           = pad_en ? pad_byte : data_byte;
        sch_ctl.fill_we    = absorb_en && (pos[1:0] == 2'b11);
        sch_ctl.fill_addr  = pos[5:2];
        rnd_ctl.chain_init = done_exit;
        rnd_ctl.t          = rnd_reg;
    end

    always_comb
    begin
        bc_next = bc_reg;
        if (done_exit)
            bc_next = 64'd0;
        else if (absorb_en)
            bc_next = bc_reg + 64'd8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bc_reg         <= 64'd0;
            rnd_reg        <= 7'd0;
            closing_reg    <= 1'b0;
            marker_reg     <= 1'b0;
            wrap_reg       <= 1'b0;
            len_done_reg   <= 1'b0;
            dout_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bc_reg    <= bc_next;
            rnd_reg   <= rnd_next;
            if (done_exit)
            begin
                closing_reg  <= 1'b0;
                marker_reg   <= 1'b0;
                wrap_reg     <= 1'b0;
                len_done_reg <= 1'b0;
            end
            else
            begin
                if (in_fire && end_of_message)
                    closing_reg <= 1'b1;
                if (pad_en && !marker_reg)
                begin
                    marker_reg <= 1'b1;
                    wrap_reg   <= (pos[5:3] == 3'b111);
                end
                else if (rnd_ctl.fold)
                    wrap_reg <= 1'b0;
                if (pad_en && len_zone && (pos == LastPos))
                    len_done_reg <= 1'b1;
            end
            if (done_exit)
                dout_valid_reg <= 1'b1;
            else if (out_ready)
                dout_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (absorb_en)
            acc_reg <= {acc_reg[15:0], abs_byte};
        if (in_fire && end_of_message)
            len_reg <= bc_reg + (has_byte ? 64'd8 : 64'd0);
        if (done_exit)
            dig_reg <= chain;
    end

    sha1h_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sch_ctl),
        .fill_data (fill_data),
        .w         (w)
    );

    sha1h_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rnd_ctl),
        .w     (w),
        .chain (chain)
    );

    assign out_valid    = dout_valid_reg;
    assign digest_word0 = dig_reg[0];
    assign digest_word1 = dig_reg[1];
    assign digest_word2 = dig_reg[2];
    assign digest_word3 = dig_reg[3];
    assign digest_word4 = dig_reg[4];

endmodule
